// ----- hw/rtl/rdu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rdu_pkg;

   // Number format of every word.
   localparam int FRAC_BITS = 14;
   localparam int WORD_BITS = 16;

   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;

   // Working width for sums and rounded products before saturation.
   localparam int SW = 2 * W + 2;
   // Working width of the restoring dividers.
   localparam int DW = 2 * W + F + 1;
   // Square root of k scaled by one: root bits and radicand width.
   localparam int RB1 = (W + F) / 2;
   localparam int Q1W = 2 * RB1;
   // Square root of the squared length: root bits and radicand width.
   localparam int RB2 = W;
   localparam int Q2W = 2 * W;

   localparam logic signed [W-1:0] SMAX = {1'b0, {(W - 1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W - 1){1'b0}}};
   localparam logic signed [W-1:0] ONE  = (F >= W - 1) ? SMAX : W'(64'd1 << F);
   localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (F - 1));

   // Pipeline stage positions.
   localparam int ST_IN   = 0;
   localparam int ST_MUL  = 1;
   localparam int ST_RND  = 2;
   localparam int ST_COS  = 3;
   localparam int ST_EDIV = 4;
   localparam int ST_ETA  = ST_EDIV + W - 1;
   localparam int ST_E2   = ST_ETA + 1;
   localparam int ST_E2R  = ST_ETA + 2;
   localparam int ST_TT   = ST_ETA + 3;
   localparam int ST_K    = ST_ETA + 4;
   localparam int ST_SQ1  = ST_K + 1;
   localparam int ST_M    = ST_SQ1 + RB1;
   localparam int ST_NM   = ST_M + 1;
   localparam int ST_T    = ST_M + 2;
   localparam int ST_SQR  = ST_M + 3;
   localparam int ST_SUM  = ST_M + 4;
   localparam int ST_SQ2  = ST_SUM + 1;
   localparam int ST_LEN  = ST_SQ2 + RB2;
   localparam int ST_NDIV = ST_LEN + 1;
   localparam int ST_OUT  = ST_NDIV + W;
   localparam int LAST    = ST_OUT;

   typedef struct packed {
      logic signed [W-1:0] normal_x;
      logic signed [W-1:0] normal_y;
      logic signed [W-1:0] normal_z;
      logic signed [W-1:0] incoming_x;
      logic signed [W-1:0] incoming_y;
      logic signed [W-1:0] incoming_z;
      logic [W-1:0]        index_from;
      logic [W-1:0]        index_to;
   } req_payload_type;

   typedef struct packed {
      logic                total_reflection;
      logic signed [W-1:0] trans_x;
      logic signed [W-1:0] trans_y;
      logic signed [W-1:0] trans_z;
   } rsp_payload_type;

   // Everything one request carries down the pipeline.
   typedef struct packed {
      logic [2:0][W-1:0]   n;
      logic [2:0][W-1:0]   d;
      logic [W-1:0]        from_ix;
      logic [W-1:0]        to_ix;
      logic [2:0][2*W-1:0] pr;
      logic [2:0][W-1:0]   rn;
      logic [W-1:0]        cosv;
      logic [DW-1:0]       erem;
      logic [W-1:0]        quo;
      logic                eovf;
      logic [W-1:0]        eta;
      logic [W-1:0]        omc;
      logic [W-1:0]        e2;
      logic [W-1:0]        ec;
      logic                tir;
      logic [Q1W-1:0]      v1;
      logic [Q1W-1:0]      r1;
      logic [W-1:0]        m;
      logic [2:0][W-1:0]   tv;
      logic [Q2W-1:0]      v2;
      logic [Q2W-1:0]      r2;
      logic [W-1:0]        len;
      logic [2:0][DW-1:0]  nrem;
      logic [2:0][W-1:0]   nq;
      logic [2:0]          novf;
   } item_type;

   // Saturate a wide signed value to the word range.
   function automatic logic [W-1:0] sat_word(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      hi = SW'(SMAX);
      lo = SW'(SMIN);
      if (v > hi) begin
         return SMAX;
      end else if (v < lo) begin
         return SMIN;
      end
      return v[W-1:0];
   endfunction

   // Sign extend a word to the working width.
   function automatic logic signed [SW-1:0] sext(input logic [W-1:0] a);
      return SW'($signed(a));
   endfunction

   // Round a full product half up by the fraction bits, then saturate.
   function automatic logic [W-1:0] fround(input logic [2*W-1:0] p);
      logic signed [SW-1:0] x;
      x = SW'($signed(p)) + HALF;
      x = x >>> F;
      return sat_word(x);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/refraction_direction_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Snell refraction unit: takes a surface normal, an incoming direction and two
// refractive indices in signed fixed point and returns the normalised
// transmitted direction, or a total reflection flag with a zero vector. It is
// a fixed pipeline that accepts one request in every cycle unless the result
// side stalls. Its depth is set by the chain of one-bit-per-stage units: the
// index ratio divider, the square root of k, the square root of the squared
// length and the three normalisation dividers.
// A stall on the result side freezes the whole pipeline and is passed
// straight back to the request side.
module refraction_direction_unit import rdu_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire req_payload_type req_data,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rsp_payload_type rsp_data
);

   item_type   item_ff [0:LAST];
   item_type   item_in [0:LAST];
   logic [LAST:0] valid_ff;
   logic [LAST:0] valid_in;
   logic          adv;

   // The pipeline moves unless a finished result is held by the receiver.
   // No request is taken while reset is asserted.
   assign adv       = !(valid_ff[LAST] && rsp_stall);
   assign req_stall = !adv || reset;
   assign valid_in  = {valid_ff[LAST-1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // Capture of the request.
   always_comb begin
      item_in[0]         = '0;
      item_in[0].n[0]    = req_data.normal_x;
      item_in[0].n[1]    = req_data.normal_y;
      item_in[0].n[2]    = req_data.normal_z;
      item_in[0].d[0]    = req_data.incoming_x;
      item_in[0].d[1]    = req_data.incoming_y;
      item_in[0].d[2]    = req_data.incoming_z;
      item_in[0].from_ix = req_data.index_from;
      item_in[0].to_ix   = req_data.index_to;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= item_in[0];
      end
   end

   for (genvar s = 1; s <= LAST; s++) begin : g_stage

      if (s == ST_MUL) begin : g_mul
         // Products of the dot product.
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int j = 0; j < 3; j++) begin
               item_in[s].pr[j] = $signed(item_ff[s-1].n[j]) * $signed(item_ff[s-1].d[j]);
            end
         end
      end else if (s == ST_RND) begin : g_rnd
         // Each product is rounded on its own.
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int j = 0; j < 3; j++) begin
               item_in[s].rn[j] = fround(item_ff[s-1].pr[j]);
            end
         end
      end else if (s == ST_COS) begin : g_cos
         // Cosine with the normal turned towards the incoming ray, and the
         // start of the index ratio division.
         always_comb begin
            logic [W-1:0]  c;
            logic [DW-1:0] num;
            item_in[s] = item_ff[s-1];
            c = sat_word(sext(sat_word(sext(item_ff[s-1].rn[0]) + sext(item_ff[s-1].rn[1])))
                         + sext(item_ff[s-1].rn[2]));
            item_in[s].cosv = c;
            if ($signed(c) > 0) begin
               for (int j = 0; j < 3; j++) begin
                  item_in[s].n[j] = sat_word(-sext(item_ff[s-1].n[j]));
               end
               item_in[s].cosv = sat_word(-sext(c));
            end
            num = (DW'(item_ff[s-1].from_ix) << F) + DW'(item_ff[s-1].to_ix >> 1);
            item_in[s].erem = num;
            item_in[s].eovf = num >= (DW'(item_ff[s-1].to_ix) << (W - 1));
            item_in[s].quo  = '0;
         end
      end else if (s >= ST_EDIV && s < ST_ETA) begin : g_ediv
         localparam int B = W - 2 - (s - ST_EDIV);
         // One quotient bit of the index ratio.
         always_comb begin
            logic [DW-1:0] t;
            item_in[s] = item_ff[s-1];
            t = DW'(item_ff[s-1].to_ix) << B;
            if (item_ff[s-1].erem >= t) begin
               item_in[s].erem   = item_ff[s-1].erem - t;
               item_in[s].quo[B] = 1'b1;
            end
         end
      end else if (s == ST_ETA) begin : g_eta
         // Ratio with saturation, and the square of the cosine.
         always_comb begin
            item_in[s] = item_ff[s-1];
            item_in[s].eta   = item_ff[s-1].eovf ? SMAX : item_ff[s-1].quo;
            item_in[s].pr[0] = $signed(item_ff[s-1].cosv) * $signed(item_ff[s-1].cosv);
         end
      end else if (s == ST_E2) begin : g_e2
         // Square of the ratio, and one minus the squared cosine.
         always_comb begin
            item_in[s] = item_ff[s-1];
            item_in[s].pr[1] = $signed(item_ff[s-1].eta) * $signed(item_ff[s-1].eta);
            item_in[s].omc   = sat_word(sext(ONE) - sext(fround(item_ff[s-1].pr[0])));
         end
      end else if (s == ST_E2R) begin : g_e2r
         always_comb begin
            item_in[s] = item_ff[s-1];
            item_in[s].e2 = fround(item_ff[s-1].pr[1]);
         end
      end else if (s == ST_TT) begin : g_tt
         // Scaled sine term, and the ratio times the cosine.
         always_comb begin
            item_in[s] = item_ff[s-1];
            item_in[s].pr[2] = $signed(item_ff[s-1].e2) * $signed(item_ff[s-1].omc);
            item_in[s].pr[0] = $signed(item_ff[s-1].eta) * $signed(item_ff[s-1].cosv);
         end
      end else if (s == ST_K) begin : g_k
         // k, the total reflection test and the start of its square root.
         always_comb begin
            logic [W-1:0] k;
            item_in[s] = item_ff[s-1];
            item_in[s].ec = fround(item_ff[s-1].pr[0]);
            k = sat_word(sext(ONE) - sext(fround(item_ff[s-1].pr[2])));
            item_in[s].tir = k[W-1];
            item_in[s].v1  = k[W-1] ? '0 : (Q1W'(k) << F);
            item_in[s].r1  = '0;
         end
      end else if (s >= ST_SQ1 && s < ST_M) begin : g_sq1
         localparam int I = s - ST_SQ1;
         // One root bit of sqrt(k).
         always_comb begin
            logic [Q1W-1:0] bt;
            logic [Q1W:0]   tr;
            item_in[s] = item_ff[s-1];
            bt = Q1W'(1) << (2 * (RB1 - 1 - I));
            tr = {1'b0, item_ff[s-1].r1} + {1'b0, bt};
            if ({1'b0, item_ff[s-1].v1} >= tr) begin
               item_in[s].v1 = item_ff[s-1].v1 - tr[Q1W-1:0];
               item_in[s].r1 = (item_ff[s-1].r1 >> 1) + bt;
            end else begin
               item_in[s].r1 = item_ff[s-1].r1 >> 1;
            end
         end
      end else if (s == ST_M) begin : g_m
         // Normal scale, and the ratio times the incoming direction.
         always_comb begin
            item_in[s] = item_ff[s-1];
            item_in[s].m = sat_word(sext(item_ff[s-1].ec) + SW'(item_ff[s-1].r1[RB1-1:0]));
            for (int j = 0; j < 3; j++) begin
               item_in[s].pr[j] = $signed(item_ff[s-1].eta) * $signed(item_ff[s-1].d[j]);
            end
         end
      end else if (s == ST_NM) begin : g_nm
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int j = 0; j < 3; j++) begin
               item_in[s].rn[j] = fround(item_ff[s-1].pr[j]);
               item_in[s].pr[j] = $signed(item_ff[s-1].n[j]) * $signed(item_ff[s-1].m);
            end
         end
      end else if (s == ST_T) begin : g_t
         // Unnormalised transmitted direction.
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int j = 0; j < 3; j++) begin
               item_in[s].tv[j] = sat_word(sext(item_ff[s-1].rn[j])
                                           - sext(fround(item_ff[s-1].pr[j])));
            end
         end
      end else if (s == ST_SQR) begin : g_sqr
         always_comb begin
            item_in[s] = item_ff[s-1];
            for (int j = 0; j < 3; j++) begin
               item_in[s].pr[j] = $signed(item_ff[s-1].tv[j]) * $signed(item_ff[s-1].tv[j]);
            end
         end
      end else if (s == ST_SUM) begin : g_sum
         // Exact squared length, and the start of its square root.
         always_comb begin
            item_in[s] = item_ff[s-1];
            item_in[s].v2 = Q2W'(item_ff[s-1].pr[0]) + Q2W'(item_ff[s-1].pr[1])
                            + Q2W'(item_ff[s-1].pr[2]);
            item_in[s].r2 = '0;
         end
      end else if (s >= ST_SQ2 && s < ST_LEN) begin : g_sq2
         localparam int I = s - ST_SQ2;
         // One root bit of the length.
         always_comb begin
            logic [Q2W-1:0] bt;
            logic [Q2W:0]   tr;
            item_in[s] = item_ff[s-1];
            bt = Q2W'(1) << (2 * (RB2 - 1 - I));
            tr = {1'b0, item_ff[s-1].r2} + {1'b0, bt};
            if ({1'b0, item_ff[s-1].v2} >= tr) begin
               item_in[s].v2 = item_ff[s-1].v2 - tr[Q2W-1:0];
               item_in[s].r2 = (item_ff[s-1].r2 >> 1) + bt;
            end else begin
               item_in[s].r2 = item_ff[s-1].r2 >> 1;
            end
         end
      end else if (s == ST_LEN) begin : g_len
         // Length, and the start of the three normalising divisions.
         always_comb begin
            logic [W-1:0]  l;
            logic [W-1:0]  mag;
            logic [DW-1:0] num;
            item_in[s] = item_ff[s-1];
            l = item_ff[s-1].r2[W-1:0];
            item_in[s].len = l;
            for (int j = 0; j < 3; j++) begin
               mag = item_ff[s-1].tv[j][W-1] ? (~item_ff[s-1].tv[j] + 1'b1)
                                             : item_ff[s-1].tv[j];
               num = (DW'(mag) << F) + DW'(l >> 1);
               item_in[s].nrem[j] = num;
               item_in[s].novf[j] = num >= (DW'(l) << W);
               item_in[s].nq[j]   = '0;
            end
         end
      end else if (s >= ST_NDIV && s < ST_OUT) begin : g_ndiv
         localparam int B = W - 1 - (s - ST_NDIV);
         // One quotient bit of each component.
         always_comb begin
            logic [DW-1:0] t;
            item_in[s] = item_ff[s-1];
            t = DW'(item_ff[s-1].len) << B;
            for (int j = 0; j < 3; j++) begin
               if (item_ff[s-1].nrem[j] >= t) begin
                  item_in[s].nrem[j]  = item_ff[s-1].nrem[j] - t;
                  item_in[s].nq[j][B] = 1'b1;
               end
            end
         end
      end else begin : g_out
         // Clamp, restore the sign and blank the vector when there is none.
         always_comb begin
            logic [W-1:0] lim;
            logic [W-1:0] qc;
            item_in[s] = item_ff[s-1];
            lim = {1'b1, {(W - 1){1'b0}}};
            for (int j = 0; j < 3; j++) begin
               qc = (item_ff[s-1].novf[j] || item_ff[s-1].nq[j] > lim) ? lim
                                                                      : item_ff[s-1].nq[j];
               if (item_ff[s-1].tir || item_ff[s-1].len == '0) begin
                  item_in[s].rn[j] = '0;
               end else if (item_ff[s-1].tv[j][W-1]) begin
                  item_in[s].rn[j] = ~qc + 1'b1;
               end else begin
                  item_in[s].rn[j] = (qc == lim) ? SMAX : qc;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            item_ff[s] <= item_in[s];
         end
      end
   end

   // Result from the last stage.
   assign rsp_valid                 = valid_ff[LAST];
   assign rsp_data.total_reflection = item_ff[LAST].tir;
   assign rsp_data.trans_x          = item_ff[LAST].rn[0];
   assign rsp_data.trans_y          = item_ff[LAST].rn[1];
   assign rsp_data.trans_z          = item_ff[LAST].rn[2];

   // A total reflection always comes with a zero vector.
   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.total_reflection |->
         rsp_data.trans_x == '0 && rsp_data.trans_y == '0 && rsp_data.trans_z == '0)
      else $error("total reflection with a non-zero vector");

   // The index ratio is never negative.
   a_eta_sign: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_ETA] |-> !item_ff[ST_ETA].eta[W-1])
      else $error("negative index ratio");

   // A request in the stage before last reaches the output on the next move.
   a_reach: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST-1] && adv |=> rsp_valid)
      else $error("request lost before the output stage");

endmodule

`default_nettype wire
